>>> design/stsc_pkg.sv
`timescale 1ns / 1ps

package stsc_pkg;

   // Text limits; positions and lengths saturate at the smaller of the two
   localparam int MAX_TEXT = 65536;
   localparam int POS_W = 16;
   localparam logic [POS_W-1:0] POS_LIMIT =
      (MAX_TEXT - 1 > 65535) ? 16'hFFFF : POS_W'(MAX_TEXT - 1);

   localparam int KIND_W = 6;
   localparam int VALUE_W = 63;
   localparam logic [VALUE_W-1:0] NUM_MAX = '1;

   // Keyword set
   localparam int KW_COUNT = 21;
   localparam int KW_MAX_LEN = 8;
   localparam logic [KW_COUNT-1:0] MASK_ALL = '1;

   // Result queue between scanner and output
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Token kinds
   localparam logic [KIND_W-1:0] KIND_ERROR   = 6'd0;
   localparam logic [KIND_W-1:0] KIND_END     = 6'd1;
   localparam logic [KIND_W-1:0] KIND_IDENT   = 6'd2;
   localparam logic [KIND_W-1:0] KIND_NUMBER  = 6'd3;
   localparam logic [KIND_W-1:0] KIND_STRING  = 6'd4;
   localparam logic [KIND_W-1:0] KIND_COMMA   = 6'd5;
   localparam logic [KIND_W-1:0] KIND_LPAREN  = 6'd6;
   localparam logic [KIND_W-1:0] KIND_RPAREN  = 6'd7;
   localparam logic [KIND_W-1:0] KIND_PLUS    = 6'd8;
   localparam logic [KIND_W-1:0] KIND_MINUS   = 6'd9;
   localparam logic [KIND_W-1:0] KIND_STAR    = 6'd10;
   localparam logic [KIND_W-1:0] KIND_SLASH   = 6'd11;
   localparam logic [KIND_W-1:0] KIND_PERCENT = 6'd12;
   localparam logic [KIND_W-1:0] KIND_EQ      = 6'd13;
   localparam logic [KIND_W-1:0] KIND_LT      = 6'd14;
   localparam logic [KIND_W-1:0] KIND_LE      = 6'd15;
   localparam logic [KIND_W-1:0] KIND_GT      = 6'd16;
   localparam logic [KIND_W-1:0] KIND_GE      = 6'd17;
   localparam logic [KIND_W-1:0] KIND_NE      = 6'd18;
   localparam logic [KIND_W-1:0] KIND_KW_BASE = 6'd19;

   typedef struct packed {
      logic [KIND_W-1:0]  token_kind;
      logic [VALUE_W-1:0] number_value;
      logic [POS_W-1:0]   text_start;
      logic [POS_W-1:0]   text_length;
      logic               last;
   } token_type;

   // Up to two tokens produced by one character, oldest in tok_a
   typedef struct packed {
      logic [1:0] count;
      token_type  tok_a;
      token_type  tok_b;
   } token_pair_type;

   function automatic token_type token_make(input logic [KIND_W-1:0] kind,
                                            input logic [VALUE_W-1:0] value,
                                            input logic [POS_W-1:0] start,
                                            input logic [POS_W-1:0] length);
      token_type t;
      t.token_kind = kind;
      t.number_value = value;
      t.text_start = start;
      t.text_length = length;
      t.last = 1'b0;
      return t;
   endfunction

   function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
      return (v < POS_LIMIT) ? v + POS_W'(1) : POS_LIMIT;
   endfunction

   // Keyword spellings, alphabetical; text is right-aligned in the word
   function automatic logic [8*KW_MAX_LEN-1:0] kw_text(input int k);
      logic [8*KW_MAX_LEN-1:0] w;
      case (k)
         0:       w = "all";
         1:       w = "and";
         2:       w = "create";
         3:       w = "delete";
         4:       w = "drop";
         5:       w = "from";
         6:       w = "in";
         7:       w = "insert";
         8:       w = "into";
         9:       w = "like";
         10:      w = "long";
         11:      w = "not";
         12:      w = "or";
         13:      w = "select";
         14:      w = "set";
         15:      w = "table";
         16:      w = "text";
         17:      w = "truncate";
         18:      w = "update";
         19:      w = "values";
         20:      w = "where";
         default: w = '0;
      endcase
      return w;
   endfunction

   function automatic logic [3:0] kw_len(input int k);
      logic [3:0] n;
      case (k)
         0, 1, 11, 14:          n = 4'd3;
         2, 3, 7, 13, 18, 19:   n = 4'd6;
         4, 5, 8, 9, 10, 16:    n = 4'd4;
         6, 12:                 n = 4'd2;
         15, 20:                n = 4'd5;
         17:                    n = 4'd8;
         default:               n = 4'd0;
      endcase
      return n;
   endfunction

   // Character i of keyword k, zero past its end
   function automatic logic [7:0] kw_char(input int k, input int i);
      logic [8*KW_MAX_LEN-1:0] w;
      int n;
      logic [7:0] ch;
      w = kw_text(k);
      n = int'(kw_len(k));
      ch = 8'h00;
      if (i < n) begin
         ch = w[8*(n-1-i) +: 8];
      end
      return ch;
   endfunction

endpackage

>>> design/stsc_front.sv
`timescale 1ns / 1ps

module stsc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              char_code,
   input  logic                    first,
   output stsc_pkg::token_pair_type pair
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_WORD, ST_STRING, ST_LT, ST_GT, ST_BANG, ST_NUMBER
   } state_type;

   typedef enum logic [4:0] {
      CL_LET, CL_DIG, CL_APO, CL_COMMA, CL_LBR, CL_RBR, CL_PLUS, CL_MINUS,
      CL_STAR, CL_SLASH, CL_PCT, CL_LT, CL_GT, CL_EQ, CL_BANG, CL_DELIM,
      CL_EOT, CL_OTHER
   } class_type;

   localparam int POS_W = stsc_pkg::POS_W;
   localparam int VALUE_W = stsc_pkg::VALUE_W;
   localparam int KW_COUNT = stsc_pkg::KW_COUNT;

   function automatic class_type classify(input logic [7:0] c);
      class_type cl;
      if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_") begin
         cl = CL_LET;
      end else if (c >= "0" && c <= "9") begin
         cl = CL_DIG;
      end else begin
         case (c)
            "'":                    cl = CL_APO;
            ",":                    cl = CL_COMMA;
            "(":                    cl = CL_LBR;
            ")":                    cl = CL_RBR;
            "+":                    cl = CL_PLUS;
            "-":                    cl = CL_MINUS;
            "*":                    cl = CL_STAR;
            "/":                    cl = CL_SLASH;
            "%":                    cl = CL_PCT;
            "<":                    cl = CL_LT;
            ">":                    cl = CL_GT;
            "=":                    cl = CL_EQ;
            "!":                    cl = CL_BANG;
            ";", 8'h00:             cl = CL_EOT;
            " ", 8'h09, 8'h0A, 8'h0D: cl = CL_DELIM;
            default:                cl = CL_OTHER;
         endcase
      end
      return cl;
   endfunction

   state_type              state_ff, state_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [POS_W-1:0]       begin_ff, begin_in;
   logic [VALUE_W-1:0]     acc_ff, acc_in;
   logic [KW_COUNT-1:0]    mask_ff, mask_in;
   logic [POS_W-1:0]       len_ff, len_in;

   state_type              cur_state;
   logic [POS_W-1:0]       cur_pos, cur_begin, cur_len;
   logic [VALUE_W-1:0]     cur_acc;
   logic [KW_COUNT-1:0]    cur_mask;
   class_type              cls;
   logic [7:0]             lc;
   logic [3:0]             digit;
   logic [KW_COUNT-1:0]    word_hit, start_hit;
   logic [stsc_pkg::KIND_W-1:0] word_kind;
   logic [VALUE_W+3:0]     acc_x10d;
   logic                   acc_sat;
   logic                   emit_a, emit_b, do_idle;
   stsc_pkg::token_type    tok_a, tok_b;

   // Apply the restart flag, classify, and match keyword characters
   always_comb begin
      cur_state = first ? ST_IDLE : state_ff;
      cur_pos   = first ? '0 : pos_ff;
      cur_begin = first ? '0 : begin_ff;
      cur_len   = first ? '0 : len_ff;
      cur_acc   = first ? '0 : acc_ff;
      cur_mask  = first ? stsc_pkg::MASK_ALL : mask_ff;

      cls = classify(char_code);
      lc = (char_code >= "A" && char_code <= "Z") ? (char_code | 8'h20) : char_code;
      digit = char_code[3:0];

      for (int k = 0; k < KW_COUNT; k++) begin
         word_hit[k] = 1'b0;
         for (int i = 0; i < stsc_pkg::KW_MAX_LEN; i++) begin
            if (cur_len[2:0] == 3'(i)) begin
               word_hit[k] = (lc == stsc_pkg::kw_char(k, i));
            end
         end
         if (cur_len >= POS_W'(stsc_pkg::KW_MAX_LEN)) begin
            word_hit[k] = 1'b0;
         end
         start_hit[k] = (lc == stsc_pkg::kw_char(k, 0));
      end

      // First live keyword of the right length wins
      word_kind = stsc_pkg::KIND_IDENT;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (cur_mask[k] && cur_len == POS_W'(stsc_pkg::kw_len(k))) begin
            word_kind = stsc_pkg::KIND_KW_BASE + stsc_pkg::KIND_W'(k);
         end
      end

      // Decimal accumulate: acc * 10 + digit, saturating
      acc_x10d = {1'b0, cur_acc, 3'b000} + {3'b000, cur_acc, 1'b0}
               + {{VALUE_W{1'b0}}, digit};
      acc_sat = |acc_x10d[VALUE_W+3:VALUE_W];
   end

   // Scan the character in the current state, then rescan from idle if it ended a token
   always_comb begin
      state_in = cur_state;
      begin_in = cur_begin;
      len_in = cur_len;
      acc_in = cur_acc;
      mask_in = cur_mask;
      emit_a = 1'b0;
      emit_b = 1'b0;
      do_idle = 1'b0;
      tok_a = stsc_pkg::token_make(stsc_pkg::KIND_ERROR, '0, '0, '0);
      tok_b = stsc_pkg::token_make(stsc_pkg::KIND_ERROR, '0, '0, '0);

      case (cur_state)
         ST_WORD: begin
            if (cls == CL_LET || cls == CL_DIG) begin
               mask_in = cur_mask & word_hit;
               len_in = stsc_pkg::sat_inc(cur_len);
            end else begin
               emit_a = 1'b1;
               tok_a = stsc_pkg::token_make(word_kind, '0, cur_begin, cur_len);
               do_idle = 1'b1;
            end
         end
         ST_STRING: begin
            if (cls == CL_APO) begin
               emit_a = 1'b1;
               tok_a = stsc_pkg::token_make(stsc_pkg::KIND_STRING, '0,
                                            cur_begin + POS_W'(1), cur_len);
               state_in = ST_IDLE;
            end else if (char_code == 8'h00) begin
               emit_a = 1'b1;
               tok_a = stsc_pkg::token_make(stsc_pkg::KIND_ERROR, '0, cur_pos,
                                            POS_W'(1));
               state_in = ST_IDLE;
            end else begin
               len_in = stsc_pkg::sat_inc(cur_len);
            end
         end
         ST_LT, ST_GT: begin
            emit_a = 1'b1;
            if (cls == CL_EQ) begin
               tok_a = stsc_pkg::token_make((cur_state == ST_LT) ? stsc_pkg::KIND_LE
                                            : stsc_pkg::KIND_GE, '0, cur_begin,
                                            POS_W'(2));
               state_in = ST_IDLE;
            end else begin
               tok_a = stsc_pkg::token_make((cur_state == ST_LT) ? stsc_pkg::KIND_LT
                                            : stsc_pkg::KIND_GT, '0, cur_begin,
                                            POS_W'(1));
               do_idle = 1'b1;
            end
         end
         ST_BANG: begin
            emit_a = 1'b1;
            if (cls == CL_EQ) begin
               tok_a = stsc_pkg::token_make(stsc_pkg::KIND_NE, '0, cur_begin,
                                            POS_W'(2));
            end else begin
               tok_a = stsc_pkg::token_make(stsc_pkg::KIND_ERROR, '0, cur_pos,
                                            POS_W'(1));
            end
            state_in = ST_IDLE;
         end
         ST_NUMBER: begin
            if (cls == CL_DIG) begin
               acc_in = acc_sat ? stsc_pkg::NUM_MAX : acc_x10d[VALUE_W-1:0];
               len_in = stsc_pkg::sat_inc(cur_len);
            end else begin
               emit_a = 1'b1;
               tok_a = stsc_pkg::token_make(stsc_pkg::KIND_NUMBER, cur_acc,
                                            cur_begin, cur_len);
               do_idle = 1'b1;
            end
         end
         default: begin
            do_idle = 1'b1;
         end
      endcase

      // Idle pass: start a token, skip a delimiter, or emit a one-character result
      if (do_idle) begin
         state_in = ST_IDLE;
         case (cls)
            CL_LET: begin
               begin_in = cur_pos;
               acc_in = '0;
               mask_in = start_hit;
               len_in = POS_W'(1);
               state_in = ST_WORD;
            end
            CL_APO, CL_LT, CL_GT, CL_BANG: begin
               begin_in = cur_pos;
               acc_in = '0;
               mask_in = stsc_pkg::MASK_ALL;
               len_in = '0;
               case (cls)
                  CL_APO:  state_in = ST_STRING;
                  CL_LT:   state_in = ST_LT;
                  CL_GT:   state_in = ST_GT;
                  default: state_in = ST_BANG;
               endcase
            end
            CL_DIG: begin
               begin_in = cur_pos;
               acc_in = VALUE_W'(digit);
               mask_in = stsc_pkg::MASK_ALL;
               len_in = POS_W'(1);
               state_in = ST_NUMBER;
            end
            CL_COMMA: begin
               emit_b = 1'b1;
               tok_b = stsc_pkg::token_make(stsc_pkg::KIND_COMMA, '0, cur_pos, POS_W'(1));
            end
            CL_LBR: begin
               emit_b = 1'b1;
               tok_b = stsc_pkg::token_make(stsc_pkg::KIND_LPAREN, '0, cur_pos, POS_W'(1));
            end
            CL_RBR: begin
               emit_b = 1'b1;
               tok_b = stsc_pkg::token_make(stsc_pkg::KIND_RPAREN, '0, cur_pos, POS_W'(1));
            end
            CL_PLUS: begin
               emit_b = 1'b1;
               tok_b = stsc_pkg::token_make(stsc_pkg::KIND_PLUS, '0, cur_pos, POS_W'(1));
            end
            CL_MINUS: begin
               emit_b = 1'b1;
               tok_b = stsc_pkg::token_make(stsc_pkg::KIND_MINUS, '0, cur_pos, POS_W'(1));
            end
            CL_STAR: begin
               emit_b = 1'b1;
               tok_b = stsc_pkg::token_make(stsc_pkg::KIND_STAR, '0, cur_pos, POS_W'(1));
            end
            CL_SLASH: begin
               emit_b = 1'b1;
               tok_b = stsc_pkg::token_make(stsc_pkg::KIND_SLASH, '0, cur_pos, POS_W'(1));
            end
            CL_PCT: begin
               emit_b = 1'b1;
               tok_b = stsc_pkg::token_make(stsc_pkg::KIND_PERCENT, '0, cur_pos,
                                            POS_W'(1));
            end
            CL_EQ: begin
               emit_b = 1'b1;
               tok_b = stsc_pkg::token_make(stsc_pkg::KIND_EQ, '0, cur_pos, POS_W'(1));
            end
            CL_DELIM: begin
               emit_b = 1'b0;
            end
            CL_EOT: begin
               emit_b = 1'b1;
               tok_b = stsc_pkg::token_make(stsc_pkg::KIND_END, '0, cur_pos, '0);
            end
            default: begin
               emit_b = 1'b1;
               tok_b = stsc_pkg::token_make(stsc_pkg::KIND_ERROR, '0, cur_pos, POS_W'(1));
            end
         endcase
      end

      pos_in = stsc_pkg::sat_inc(cur_pos);
   end

   // Pack the tokens in order and mark the final one
   always_comb begin
      pair.count = accept ? (2'(emit_a) + 2'(emit_b)) : 2'd0;
      pair.tok_a = emit_a ? tok_a : tok_b;
      pair.tok_a.last = !(emit_a && emit_b);
      pair.tok_b = tok_b;
      pair.tok_b.last = 1'b1;
   end

   // Hold scanner state; advance on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff <= '0;
         begin_ff <= '0;
         len_ff <= '0;
         acc_ff <= '0;
         mask_ff <= stsc_pkg::MASK_ALL;
      end else if (accept) begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         begin_ff <= begin_in;
         len_ff <= len_in;
         acc_ff <= acc_in;
         mask_ff <= mask_in;
      end
   end

endmodule

>>> design/stsc_queue.sv
`timescale 1ns / 1ps

module stsc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  stsc_pkg::token_pair_type wr_pair,
   input  logic                     pop,
   output stsc_pkg::token_type      head,
   output logic                     full,
   output logic                     empty
);

   localparam int QPTR_W = stsc_pkg::QPTR_W;
   localparam int QCNT_W = stsc_pkg::QCNT_W;

   stsc_pkg::token_type mem_ff [stsc_pkg::QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                pop_ok;

   // Room for two tokens is needed before a new item can enter
   assign full  = count_ff > QCNT_W'(stsc_pkg::QUEUE_DEPTH - 2);
   assign empty = count_ff == '0;
   assign head  = mem_ff[rd_ptr_ff];
   assign pop_ok = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(wr_pair.count);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop_ok);
      count_in  = count_ff + QCNT_W'(wr_pair.count) - QCNT_W'(pop_ok);
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Store up to two tokens per cycle
   always_ff @(posedge clock) begin
      if (wr_pair.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= wr_pair.tok_a;
      end
      if (wr_pair.count == 2'd2) begin
         mem_ff[wr_ptr_ff + QPTR_W'(1)] <= wr_pair.tok_b;
      end
   end

endmodule

>>> design/sql_token_scanner.sv
`timescale 1ns / 1ps

// SQL token scanner: one character per item in, tokens out.
// Input channel: char on req_char_code with req_first, pushed with push while
// full is low. req_first restarts the scanner and the position counter.
// Result channel: while empty is low the oldest token is on the rsp_ ports and
// is taken with pop. One character gives zero, one or two tokens; rsp_last
// marks the final token a character produced.
// Latency: a token is queued the cycle after its character is accepted.
// Throughput: one character per cycle while full is low. The scanner registers
// its state and writes its tokens into a four-entry queue; a character
// that closes one token and emits another writes two entries, so a steady
// stream of such characters runs at the one-token-per-cycle rate of the pop
// side.
// Stall: when the receiver stops popping, the queue fills and full rises once
// fewer than two entries are free; the scanner holds its state meanwhile.
// Reset: synchronous; the scanner returns to idle at position 0 and the queue
// empties. No clearing pass is needed.
module sql_token_scanner (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_char_code,
   input  logic        req_first,
   output logic        empty,
   input  logic        pop,
   output logic [5:0]  rsp_token_kind,
   output logic [62:0] rsp_number_value,
   output logic [15:0] rsp_text_start,
   output logic [15:0] rsp_text_length,
   output logic        rsp_last
);

   logic                     accept;
   stsc_pkg::token_pair_type pair;
   stsc_pkg::token_type      head;

   assign accept = push && !full;

   // Scan the character and produce its tokens
   stsc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_code (req_char_code),
      .first     (req_first),
      .pair      (pair)
   );

   // Buffer tokens toward the result side
   stsc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_pair (pair),
      .pop     (pop),
      .head    (head),
      .full    (full),
      .empty   (empty)
   );

   assign rsp_token_kind   = head.token_kind;
   assign rsp_number_value = head.number_value;
   assign rsp_text_start   = head.text_start;
   assign rsp_text_length  = head.text_length;
   assign rsp_last         = head.last;

endmodule
